FILE: rtl/core/dssm_pkg.sv
// dssm_pkg: shared types and constants for the dual stack shared memory block
// no dependencies; used by dssm_ctrl and dual_stack_shared_memory
`default_nettype none

package dssm_pkg;

    localparam int MAX_DEPTH = 256;
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = $clog2(MAX_DEPTH);
    localparam int CNT_BITS  = $clog2(MAX_DEPTH + 1);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] STACK_ONE = 2'd1;
    localparam logic [1:0] STACK_TWO = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [1:0] STATUS_BADNUM = 2'd3;

    localparam logic [1:0] LARGER_EQUAL = 2'd0;
    localparam logic [1:0] LARGER_ONE   = 2'd1;
    localparam logic [1:0] LARGER_TWO   = 2'd2;

    typedef struct packed {
        logic               command;
        logic [1:0]         stack_number;
        logic signed [31:0] data_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
        logic [8:0]         depth_one;
        logic [8:0]         depth_two;
        logic [1:0]         larger_stack;
    } out_item_t;

    // one access to the shared store
    typedef struct packed {
        logic                 en;
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] wdata;
    } mem_req_t;

    // result fields known at accept time, aligned with the read data
    typedef struct packed {
        logic                pop_ok;
        logic [1:0]          status;
        logic [CNT_BITS-1:0] depth_one;
        logic [CNT_BITS-1:0] depth_two;
        logic [1:0]          larger_stack;
    } rsp_meta_t;

endpackage

`default_nettype wire

FILE: rtl/core/dssm_ram.sv
// dssm_ram: single port synchronous ram with registered read data
// no dependencies
`default_nettype none

module dssm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/dssm_ctrl.sv
// dssm_ctrl: stack pointers, capacity register and access decode
// depends on dssm_pkg
`default_nettype none

module dssm_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire dssm_pkg::in_item_t item,
    input  wire logic               cfg_wr_en,
    input  wire logic [8:0]         cfg_wr_data,
    output dssm_pkg::mem_req_t      mem_req,
    output dssm_pkg::rsp_meta_t     meta_reg
);

    localparam logic [dssm_pkg::CNT_BITS-1:0] CNT_ONE =
        dssm_pkg::CNT_BITS'(1);
    localparam logic [dssm_pkg::CNT_BITS-1:0] CNT_MAX =
        dssm_pkg::CNT_BITS'(dssm_pkg::MAX_DEPTH);

    logic [dssm_pkg::CNT_BITS-1:0] count_one_reg, count_one_next;
    logic [dssm_pkg::CNT_BITS-1:0] count_two_reg, count_two_next;
    logic [dssm_pkg::CNT_BITS-1:0] cap_reg, cap_next;
    dssm_pkg::rsp_meta_t            meta_next;
    logic [dssm_pkg::CNT_BITS:0]    sum;
    logic [dssm_pkg::CNT_BITS-1:0]  top_two_addr;
    logic [dssm_pkg::CNT_BITS-1:0]  push_two_addr;
    logic [dssm_pkg::CNT_BITS-1:0]  pop_one_addr;
    logic [dssm_pkg::CNT_BITS-1:0]  cfg_value;
    logic [1:0]                     status;
    logic                           pop_ok;

    assign cfg_value = cfg_wr_data;
    assign sum = {1'b0, count_one_reg} + {1'b0, count_two_reg};
    // stack two's top entry sits at cap - count_two
    assign top_two_addr  = cap_reg - count_two_reg;
    assign push_two_addr = top_two_addr - CNT_ONE;
    assign pop_one_addr  = count_one_reg - CNT_ONE;

    always_comb begin
        count_one_next = count_one_reg;
        count_two_next = count_two_reg;
        cap_next       = cap_reg;
        status         = dssm_pkg::STATUS_OK;
        pop_ok         = 1'b0;
        mem_req.en     = 1'b0;
        mem_req.we     = 1'b0;
        mem_req.addr   = '0;
        mem_req.wdata  = dssm_pkg::DATA_BITS'(item.data_in);

        if (item.command == dssm_pkg::CMD_PUSH) begin
            if (sum >= {1'b0, cap_reg}) begin
                status = dssm_pkg::STATUS_FULL;
            end else begin
                case (item.stack_number)
                    dssm_pkg::STACK_ONE: begin
                        mem_req.en     = accept;
                        mem_req.we     = 1'b1;
                        mem_req.addr   = count_one_reg[dssm_pkg::ADDR_BITS-1:0];
                        count_one_next = count_one_reg + CNT_ONE;
                    end
                    dssm_pkg::STACK_TWO: begin
                        mem_req.en     = accept;
                        mem_req.we     = 1'b1;
                        mem_req.addr   = push_two_addr[dssm_pkg::ADDR_BITS-1:0];
                        count_two_next = count_two_reg + CNT_ONE;
                    end
                    default: begin
                        status = dssm_pkg::STATUS_BADNUM;
                    end
                endcase
            end
        end else begin
            case (item.stack_number)
                dssm_pkg::STACK_ONE: begin
                    if (count_one_reg == '0) begin
                        status = dssm_pkg::STATUS_EMPTY;
                    end else begin
                        pop_ok         = 1'b1;
                        mem_req.en     = accept;
                        mem_req.addr   = pop_one_addr[dssm_pkg::ADDR_BITS-1:0];
                        count_one_next = pop_one_addr;
                    end
                end
                dssm_pkg::STACK_TWO: begin
                    if (count_two_reg == '0) begin
                        status = dssm_pkg::STATUS_EMPTY;
                    end else begin
                        pop_ok         = 1'b1;
                        mem_req.en     = accept;
                        mem_req.addr   = top_two_addr[dssm_pkg::ADDR_BITS-1:0];
                        count_two_next = count_two_reg - CNT_ONE;
                    end
                end
                default: begin
                    status = dssm_pkg::STATUS_BADNUM;
                end
            endcase
        end

        meta_next.pop_ok    = pop_ok;
        meta_next.status    = status;
        meta_next.depth_one = count_one_next;
        meta_next.depth_two = count_two_next;
        if (count_one_next > count_two_next) begin
            meta_next.larger_stack = dssm_pkg::LARGER_ONE;
        end else if (count_two_next > count_one_next) begin
            meta_next.larger_stack = dssm_pkg::LARGER_TWO;
        end else begin
            meta_next.larger_stack = dssm_pkg::LARGER_EQUAL;
        end

        if (!accept) begin
            count_one_next = count_one_reg;
            count_two_next = count_two_reg;
        end

        // capacity write empties both stacks; out of range values are clamped
        if (cfg_wr_en) begin
            count_one_next = '0;
            count_two_next = '0;
            if (cfg_value == '0) begin
                cap_next = CNT_ONE;
            end else if (cfg_value > CNT_MAX) begin
                cap_next = CNT_MAX;
            end else begin
                cap_next = cfg_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_one_reg <= '0;
            count_two_reg <= '0;
            cap_reg       <= CNT_MAX;
        end else begin
            count_one_reg <= count_one_next;
            count_two_reg <= count_two_next;
            cap_reg       <= cap_next;
        end
        if (accept) begin
            meta_reg <= meta_next;
        end
    end

    a_stacks_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        sum <= {1'b0, cap_reg})
        else $error("stack depths exceed capacity");

    a_cap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_reg != '0 && cap_reg <= CNT_MAX)
        else $error("capacity out of range");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !cfg_wr_en && item.command == dssm_pkg::CMD_PUSH
            && status == dssm_pkg::STATUS_OK
        |=> sum == $past(sum) + 1'b1)
        else $error("successful push did not grow a stack");

    a_fail_no_access: assert property (@(posedge aclk) disable iff (!aresetn)
        status != dssm_pkg::STATUS_OK |-> !mem_req.en)
        else $error("failed request touched memory");

endmodule

`default_nettype wire

FILE: rtl/core/dual_stack_shared_memory.sv
// dual_stack_shared_memory: top level, two lifo stacks in one shared ram
// depends on dssm_pkg, dssm_ctrl, dssm_ram
`default_nettype none

// Two stacks share one 256 x 32 memory: stack one grows up from entry 0 and
// stack two grows down from the top of the capacity in use. Each request is
// a push or a pop on stack 1 or 2 and gives one result with the popped value
// (0 on a push or failure), a status, both depths and which stack is larger.
// The ram is read or written on accept; its read data and the result fields
// are registered, then moved to the output register. No request is taken
// while one is in flight or an untaken result waits. Writing cfg_wr_data with
// cfg_wr_en empties both stacks and sets the capacity (0 reads as 1, values
// above 256 as 256); write it only while no request is in flight.
module dual_stack_shared_memory (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire dssm_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dssm_pkg::out_item_t      m_data,
    input  wire logic                cfg_wr_en,
    input  wire logic [8:0]          cfg_wr_data
);

    dssm_pkg::mem_req_t             mem_req;
    dssm_pkg::rsp_meta_t            meta_reg;
    logic [dssm_pkg::DATA_BITS-1:0] rdata;
    logic                           accept;
    logic                           p1_valid_reg;
    logic                           m_valid_reg;
    dssm_pkg::out_item_t            m_data_reg;
    dssm_pkg::out_item_t            m_data_next;

    // the read data moves to the output register without a stall, so the output must be free
    assign s_ready = aresetn && !p1_valid_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    dssm_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .item        (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mem_req     (mem_req),
        .meta_reg    (meta_reg)
    );

    dssm_ram #(
        .DEPTH (dssm_pkg::MAX_DEPTH),
        .WIDTH (dssm_pkg::DATA_BITS)
    ) u_ram (
        .aclk  (aclk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata)
    );

    always_comb begin
        m_data_next.data_out     = meta_reg.pop_ok ? 32'(signed'(rdata)) : '0;
        m_data_next.status       = meta_reg.status;
        m_data_next.depth_one    = 9'(meta_reg.depth_one);
        m_data_next.depth_two    = 9'(meta_reg.depth_two);
        m_data_next.larger_stack = meta_reg.larger_stack;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
            if (p1_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (p1_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> !m_valid_reg || $past(m_ready))
        else $error("result overwrote an untaken result");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !accept)
        else $error("request accepted while another is in flight");

    a_pop_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && !meta_reg.pop_ok |=> m_data_reg.data_out == '0)
        else $error("nonzero data on a push or failed request");

endmodule

`default_nettype wire
